[design/pfa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Push force assist controller package
// Shared widths, register codes, reset values, mode codes and the quarter-wave
// sine table used by the assist controller.
// ----------------------------------------------------------------------------
package pfa_pkg;

  // Field widths.
  localparam int FORCE_W = 16;
  localparam int PITCH_W = 16;
  localparam int VEL_W   = 16;
  localparam int MODE_W  = 2;
  localparam int CFG_W   = 16;
  localparam int REG_IDX_W = 3;

  // Quarter-wave sine table: 2^SINE_DEPTH_LOG2 steps over a quarter turn.
  localparam int SINE_DEPTH_LOG2 = 8;
  localparam int SINE_DEPTH      = 1 << SINE_DEPTH_LOG2;
  localparam int SINE_W          = 15;

  // Pitch magnitude limit, pi/2 in 2^-14 rad.
  localparam int PMAG_W = 15;
  localparam logic [PMAG_W-1:0] HALF_PI_P = 15'd25736;

  // Index divider: numerator is |pitch| * depth + pi/4, quotient up to depth.
  localparam int NUM_W = PMAG_W + SINE_DEPTH_LOG2;
  localparam int IDX_W = SINE_DEPTH_LOG2 + 1;
  localparam logic [NUM_W-1:0] SINE_ROUND = NUM_W'(25736 / 2);

  // pi/2 in Q30 for the table build.
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Configuration register map.
  typedef enum logic [REG_IDX_W-1:0] {
    REG_PUSH_GAIN  = 3'd0,
    REG_MAX_ASSIST = 3'd1,
    REG_DEADZONE   = 3'd2,
    REG_HYSTERESIS = 3'd3,
    REG_SLOPE_GAIN = 3'd4,
    REG_DRAG_GAIN  = 3'd5
  } cfg_reg_e;

  localparam logic [15:0] PUSH_GAIN_RST  = 16'd128;
  localparam logic [14:0] MAX_ASSIST_RST = 15'd1024;
  localparam logic [14:0] DEADZONE_RST   = 15'd128;
  localparam logic [14:0] HYSTERESIS_RST = 15'd32;
  localparam logic [15:0] SLOPE_GAIN_RST = 16'd128;
  localparam logic [15:0] DRAG_GAIN_RST  = 16'd77;

  // Output mode codes.
  typedef enum logic [MODE_W-1:0] {
    MODE_IDLE   = 2'd0,
    MODE_ASSIST = 2'd1,
    MODE_BRAKE  = 2'd2
  } mode_e;

  typedef logic [SINE_W-1:0] sine_rom_t [SINE_DEPTH];

  // One table entry: Taylor series through x^13 in Q30, rounded to Q14.
  function automatic logic [SINE_W-1:0] sine_entry(input int unsigned k);
    longint unsigned x;
    longint unsigned term;
    longint unsigned q;
    longint          sum;
    x    = (longint'(k) * HALF_PI_Q30) >> SINE_DEPTH_LOG2;
    term = x;
    sum  = longint'(x);
    term = (((term * x) >> 30) * x) >> 30;
    term = term / 6;
    sum  = sum - longint'(term);
    term = (((term * x) >> 30) * x) >> 30;
    term = term / 20;
    sum  = sum + longint'(term);
    term = (((term * x) >> 30) * x) >> 30;
    term = term / 42;
    sum  = sum - longint'(term);
    term = (((term * x) >> 30) * x) >> 30;
    term = term / 72;
    sum  = sum + longint'(term);
    term = (((term * x) >> 30) * x) >> 30;
    term = term / 110;
    sum  = sum - longint'(term);
    term = (((term * x) >> 30) * x) >> 30;
    term = term / 156;
    sum  = sum + longint'(term);
    q = 0;
    if (sum > 0) begin
      q = (longint'(sum) + 32768) >> 16;
    end
    if (q > 16384) begin
      q = 16384;
    end
    return SINE_W'(q);
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int unsigned k = 0; k < SINE_DEPTH; k++) begin
      rom[k] = sine_entry(k);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();
  // The entry at exactly a quarter turn sits outside the power-of-two table.
  localparam logic [SINE_W-1:0] SINE_TOP = sine_entry(SINE_DEPTH);

endpackage

[design/pfa_tick_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Control tick channel
// Valid/ready channel carrying one control tick: force and pitch samples.
// ----------------------------------------------------------------------------
interface pfa_tick_if;
  import pfa_pkg::*;

  logic               valid;
  logic               ready;
  logic [FORCE_W-1:0] force_sample;
  logic               force_valid;
  logic [PITCH_W-1:0] pitch_sample;
  logic               pitch_valid;

  modport source (
    output valid, force_sample, force_valid, pitch_sample, pitch_valid,
    input  ready
  );

  modport sink (
    input  valid, force_sample, force_valid, pitch_sample, pitch_valid,
    output ready
  );
endinterface

[design/pfa_cmd_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Velocity command channel
// Valid/ready channel carrying one velocity request and its mode.
// ----------------------------------------------------------------------------
interface pfa_cmd_if;
  import pfa_pkg::*;

  logic              valid;
  logic              ready;
  logic [VEL_W-1:0]  velocity_request;
  logic [MODE_W-1:0] mode;

  modport source (
    output valid, velocity_request, mode,
    input  ready
  );

  modport sink (
    input  valid, velocity_request, mode,
    output ready
  );
endinterface

[design/push_force_assist_controller_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Push force assist controller
// Turns handle force and pitch samples into a velocity request with assist,
// brake and idle modes, using a serial divider and a serial multiplier.
// ----------------------------------------------------------------------------
//
//   Channel   Dir   Beat contents
//   --------  ----  ---------------------------------------------------------
//   tick      in    force_sample, force_valid, pitch_sample, pitch_valid
//   cmd       out   velocity_request, mode
//   wr_*      in    register write: wr_en, wr_index, wr_data (no handshake)
//
// Each tick beat yields exactly one cmd beat. The block works on one tick at
// a time: it takes no new tick until the cmd beat for the last one has been
// loaded into the output register. The work is done by the 9-step index
// divider and one 16-step pass of the serial multiplier, plus a second pass
// when assist or brake is active. The cmd output is registered, so a new tick
// is accepted while the previous command waits; a stalled cmd only holds up
// the end of the next tick. Reset is synchronous and brings the held samples,
// the assist flag and the registers back to their defaults; no clearing pass
// is needed.
// ----------------------------------------------------------------------------
module push_force_assist_controller_top (
  input  logic clk,
  input  logic rst,
  pfa_tick_if.sink  tick,
  pfa_cmd_if.source cmd,
  input  logic                            wr_en,
  input  logic [pfa_pkg::REG_IDX_W-1:0]   wr_index,
  input  logic [pfa_pkg::CFG_W-1:0]       wr_data
);
  import pfa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_GRAV,
    S_DECIDE,
    S_VEL,
    S_OUT
  } state_t;

  state_t state;

  // Configuration registers.
  logic [15:0] push_gain;
  logic [14:0] max_assist;
  logic [14:0] deadzone;
  logic [14:0] hysteresis;
  logic [15:0] slope_gain;
  logic [15:0] drag_gain;

  // Held samples and control state.
  logic [FORCE_W-1:0] held_force;
  logic [PITCH_W-1:0] held_pitch;
  logic               assist_on;
  logic               pitch_neg;
  logic [16:0]        force_eff;
  mode_e              mode_reg;
  logic [VEL_W-1:0]   vel_reg;

  // Output register.
  logic               out_valid;
  logic [VEL_W-1:0]   out_vel;
  mode_e              out_mode;

  // Datapath signals.
  logic               accept;
  logic [PITCH_W-1:0] pitch_new;
  logic [16:0]        pitch_ext;
  logic [16:0]        pitch_abs;
  logic [PMAG_W-1:0]  pitch_mag;
  logic [NUM_W-1:0]   div_numer;
  logic               div_done;
  logic [IDX_W-1:0]   div_quot;
  logic [SINE_W-1:0]  sine_mag;
  logic               mul_start;
  logic [15:0]        mul_mcand;
  logic [15:0]        mul_mplier;
  logic               mul_done;
  logic [31:0]        mul_product;
  logic [32:0]        grav_sum;
  logic [15:0]        grav;
  logic [16:0]        force_ext;
  logic [16:0]        force_grav;
  logic [17:0]        f_wide;
  logic [17:0]        on_th;
  logic [17:0]        off_th;
  logic [17:0]        brake_sum;
  logic               above_on;
  logic               below_off;
  logic               below_dz;
  logic               on_next;
  mode_e              mode_next;
  logic [16:0]        f_abs;
  logic [15:0]        gain_sel;
  logic [32:0]        vel_sum;
  logic [28:0]        vel_mag;
  logic [14:0]        brake_lim;
  logic [VEL_W-1:0]   vel_next;

  // --------------------------------------------------------------------------
  // Register writes. Unused indexes are dropped.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      push_gain  <= PUSH_GAIN_RST;
      max_assist <= MAX_ASSIST_RST;
      deadzone   <= DEADZONE_RST;
      hysteresis <= HYSTERESIS_RST;
      slope_gain <= SLOPE_GAIN_RST;
      drag_gain  <= DRAG_GAIN_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_PUSH_GAIN:  push_gain  <= wr_data;
        REG_MAX_ASSIST: max_assist <= wr_data[14:0];
        REG_DEADZONE:   deadzone   <= wr_data[14:0];
        REG_HYSTERESIS: hysteresis <= wr_data[14:0];
        REG_SLOPE_GAIN: slope_gain <= wr_data;
        REG_DRAG_GAIN:  drag_gain  <= wr_data;
        default: ;
      endcase
    end
  end

  assign accept     = tick.valid & tick.ready;
  assign tick.ready = (state == S_IDLE);

  // --------------------------------------------------------------------------
  // Sine index: |pitch| is saturated at a quarter turn, then scaled to the
  // table and divided by pi/2 with rounding to the nearest step.
  // --------------------------------------------------------------------------
  assign pitch_new = tick.pitch_valid ? tick.pitch_sample : held_pitch;
  assign pitch_ext = {pitch_new[PITCH_W-1], pitch_new};
  assign pitch_abs = pitch_new[PITCH_W-1] ? (~pitch_ext + 17'd1) : pitch_ext;
  assign pitch_mag = (pitch_abs > {2'b00, HALF_PI_P}) ? HALF_PI_P : pitch_abs[PMAG_W-1:0];
  assign div_numer = {pitch_mag, {SINE_DEPTH_LOG2{1'b0}}} + SINE_ROUND;

  pfa_index_div u_index_div (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .numer (div_numer),
    .done  (div_done),
    .quot  (div_quot)
  );

  // The top index is exactly a quarter turn.
  always_comb begin
    if (div_quot[IDX_W-1]) begin
      sine_mag = SINE_TOP;
    end else begin
      sine_mag = SINE_ROM[div_quot[IDX_W-2:0]];
    end
  end

  // --------------------------------------------------------------------------
  // Shared multiplier: first slope_gain times |sine|, then |force| times the
  // selected gain. Both results are rounded half away from zero on the
  // magnitude and the sign is put back afterwards.
  // --------------------------------------------------------------------------
  assign mul_start  = ((state == S_DIV) && div_done) ||
                      ((state == S_DECIDE) && (mode_next != MODE_IDLE));
  assign mul_mcand  = (state == S_DIV) ? {1'b0, sine_mag} : f_abs[15:0];
  assign mul_mplier = (state == S_DIV) ? slope_gain : gain_sel;

  pfa_serial_mul #(
    .WIDTH (16)
  ) u_serial_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand   (mul_mcand),
    .mplier  (mul_mplier),
    .done    (mul_done),
    .product (mul_product)
  );

  // Gravity term in 1/64 N. The sine is at most 1.0, so it fits 15 bits.
  assign grav_sum   = {1'b0, mul_product} + 33'd32768;
  assign grav       = grav_sum[31:16];
  assign force_ext  = {held_force[FORCE_W-1], held_force};
  assign force_grav = pitch_neg ? (force_ext + {1'b0, grav}) : (force_ext - {1'b0, grav});

  // --------------------------------------------------------------------------
  // Mode decision with hysteresis around the dead zone. The off threshold
  // goes negative when the hysteresis is wider than the dead zone.
  // --------------------------------------------------------------------------
  assign f_wide    = {force_eff[16], force_eff};
  assign on_th     = {3'b000, deadzone} + {3'b000, hysteresis};
  assign off_th    = {3'b000, deadzone} - {3'b000, hysteresis};
  assign brake_sum = f_wide + {3'b000, deadzone};
  assign above_on  = $signed(f_wide) > $signed(on_th);
  assign below_off = $signed(f_wide) < $signed(off_th);
  assign below_dz  = brake_sum[17];
  assign on_next   = assist_on ? !below_off : above_on;
  assign f_abs     = force_eff[16] ? (~force_eff + 17'd1) : force_eff;
  assign gain_sel  = on_next ? push_gain : drag_gain;

  always_comb begin
    if (on_next) begin
      mode_next = MODE_ASSIST;
    end else if (below_dz) begin
      mode_next = MODE_BRAKE;
    end else begin
      mode_next = MODE_IDLE;
    end
  end

  // --------------------------------------------------------------------------
  // Velocity: divide by 16 with rounding, then clamp. Assist is limited only
  // at the top; a negative force under assist saturates at the 16-bit floor.
  // Brake always comes from a negative force and is floored at -max_assist.
  // --------------------------------------------------------------------------
  assign vel_sum   = {1'b0, mul_product} + 33'd8;
  assign vel_mag   = vel_sum[32:4];
  assign brake_lim = (vel_mag > {14'd0, max_assist}) ? max_assist : vel_mag[14:0];

  always_comb begin
    if ((mode_reg == MODE_ASSIST) && !force_eff[16]) begin
      vel_next = (vel_mag > {14'd0, max_assist}) ? {1'b0, max_assist} : vel_mag[15:0];
    end else if (mode_reg == MODE_ASSIST) begin
      vel_next = (vel_mag > 29'd32768) ? 16'h8000 : (~vel_mag[15:0] + 16'd1);
    end else begin
      vel_next = ~{1'b0, brake_lim} + 16'd1;
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer and output register.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      held_force <= '0;
      held_pitch <= '0;
      assist_on  <= 1'b0;
      mode_reg   <= MODE_IDLE;
      out_valid  <= 1'b0;
    end else begin
      // A beat leaving the output register frees it, unless the sequencer
      // loads the next command in the same cycle.
      if (out_valid && cmd.ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (tick.force_valid) begin
              held_force <= tick.force_sample;
            end
            held_pitch <= pitch_new;
            pitch_neg  <= pitch_new[PITCH_W-1];
            state      <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_GRAV;
          end
        end
        S_GRAV: begin
          if (mul_done) begin
            force_eff <= force_grav;
            state     <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          assist_on <= on_next;
          mode_reg  <= mode_next;
          if (mode_next == MODE_IDLE) begin
            vel_reg <= '0;
            state   <= S_OUT;
          end else begin
            state <= S_VEL;
          end
        end
        S_VEL: begin
          if (mul_done) begin
            vel_reg <= vel_next;
            state   <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || cmd.ready) begin
            out_valid <= 1'b1;
            out_vel   <= vel_reg;
            out_mode  <= mode_reg;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign cmd.valid            = out_valid;
  assign cmd.velocity_request = out_vel;
  assign cmd.mode             = out_mode;

endmodule

[design/pfa_serial_mul.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial multiplier
// Unsigned shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module pfa_serial_mul #(
  parameter int WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [WIDTH-1:0]   mcand,
  input  logic [WIDTH-1:0]   mplier,
  output logic               done,
  output logic [2*WIDTH-1:0] product
);

  localparam int CNT_W = $clog2(WIDTH);

  logic [2*WIDTH-1:0] acc;
  logic [WIDTH-1:0]   a_reg;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic [WIDTH:0]     part_sum;

  // Add to the upper half, then shift the whole accumulator right.
  assign part_sum = {1'b0, acc[2*WIDTH-1:WIDTH]} + (acc[0] ? {1'b0, a_reg} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        acc   <= {{WIDTH{1'b0}}, mplier};
        a_reg <= mcand;
        cnt   <= '0;
        busy  <= 1'b1;
      end else if (busy) begin
        acc <= {part_sum, acc[WIDTH-1:1]};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(WIDTH - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign product = acc;

endmodule

[design/pfa_index_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sine index divider
// Restoring division by pi/2 (pitch units), one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pfa_index_div (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [pfa_pkg::NUM_W-1:0] numer,
  output logic       done,
  output logic [pfa_pkg::IDX_W-1:0] quot
);
  import pfa_pkg::*;

  localparam int CNT_W = $clog2(IDX_W);

  logic [PMAG_W-1:0] rem;
  logic [IDX_W-1:0]  nq;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic [PMAG_W:0]   trial;
  logic [PMAG_W:0]   diff;
  logic              ge;

  // The remainder stays below the divisor, so the trial is below twice it.
  assign trial = {rem, nq[IDX_W-1]};
  assign ge    = trial >= {1'b0, HALF_PI_P};
  assign diff  = trial - {1'b0, HALF_PI_P};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= {1'b0, numer[NUM_W-1:IDX_W]};
        nq   <= numer[IDX_W-1:0];
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? diff[PMAG_W-1:0] : trial[PMAG_W-1:0];
        nq  <= {nq[IDX_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(IDX_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = nq;

endmodule

[design/pfa_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Push force assist controller checker
// Port-level checks on the tick and command channels, bound to the top level.
// ----------------------------------------------------------------------------
module pfa_checker (
  input logic clk,
  input logic rst,
  input logic tick_valid,
  input logic tick_ready,
  input logic cmd_valid,
  input logic cmd_ready,
  input logic [pfa_pkg::VEL_W-1:0]  cmd_velocity,
  input logic [pfa_pkg::MODE_W-1:0] cmd_mode
);
  import pfa_pkg::*;

  // The block works on one tick at a time, so it is busy right after a beat.
  a_busy_after_tick: assert property (@(posedge clk) disable iff (rst)
    tick_valid && tick_ready |=> !tick_ready)
    else $error("tick accepted in back-to-back cycles");

  // A stalled command holds its contents.
  a_cmd_hold: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd_velocity) && $stable(cmd_mode))
    else $error("stalled command changed");

  // Idle always carries a zero request.
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && (cmd_mode == MODE_IDLE) |-> (cmd_velocity == '0))
    else $error("idle command with nonzero velocity");

  // Brake never asks for forward motion.
  a_brake_sign: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && (cmd_mode == MODE_BRAKE) |->
      (cmd_velocity[VEL_W-1] || (cmd_velocity == '0)))
    else $error("brake command with positive velocity");

endmodule

bind push_force_assist_controller_top pfa_checker u_pfa_checker (
  .clk          (clk),
  .rst          (rst),
  .tick_valid   (tick.valid),
  .tick_ready   (tick.ready),
  .cmd_valid    (cmd.valid),
  .cmd_ready    (cmd.ready),
  .cmd_velocity (cmd.velocity_request),
  .cmd_mode     (cmd.mode)
);
